FILE: design/binary_min_heap_queue_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binary min-heap queue
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BMHQ_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bmhq assertion failed");

// Next-cycle implication, disabled while reset is high.
`define BMHQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bmhq assertion failed");

`endif

FILE: design/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Types, constants and helpers shared by the min-heap queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bmhq_pkg;

  // Heap capacity and derived widths.
  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int COUNT_W  = 11;

  typedef enum logic {
    MODE_INSERT  = 1'b0,
    MODE_EXTRACT = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    mode_t              mode;
    logic signed [31:0] key;
    logic        [31:0] value;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic signed   [31:0] out_key;
    logic          [31:0] out_value;
    logic [COUNT_W-1:0]   count;
  } rsp_t;

  // One heap entry as stored in memory.
  typedef struct packed {
    logic signed [31:0] key;
    logic        [31:0] value;
  } pair_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_EX_RD,
    S_EX_LOAD,
    S_DN_RD,
    S_DN_CMP,
    S_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_UP_PLACE,
    OP_UP_RD,
    OP_UP_STEP,
    OP_EX_RD,
    OP_EX_LOAD,
    OP_DN_PLACE,
    OP_DN_RD,
    OP_DN_STEP
  } op_t;

  // Controller to datapath.
  typedef struct packed {
    op_t  op;
    logic out_load;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic last_one;
    logic up_root;
    logic up_go;
    logic dn_leaf;
    logic dn_go;
  } stat_t;

  // Signed key order: lower keys are served first.
  function automatic logic key_less(input logic signed [31:0] a,
                                    input logic signed [31:0] b);
    return a < b;
  endfunction

endpackage

`default_nettype wire

FILE: design/bmhq_datapath.sv
// ----------------------------------------------------------------------------
// bmhq_datapath
// Heap memory, count, position and moving-entry registers, key compares
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_datapath (
  input  logic           clk,
  input  logic           rst,
  input  bmhq_pkg::req_t req,
  input  bmhq_pkg::cmd_t cmd,
  output bmhq_pkg::stat_t stat,
  output bmhq_pkg::rsp_t rsp
);
  import bmhq_pkg::*;

  pair_t             mem [CAPACITY];
  pair_t             rd_a;
  pair_t             rd_b;
  logic              rd_en;
  logic [ADDR_W-1:0] ra_addr;
  logic [ADDR_W-1:0] rb_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  pair_t             wr_data;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  pos;
  logic [CNT_W-1:0]  pos_next;
  pair_t             mov;
  pair_t             mov_next;

  status_t            res_status;
  logic signed [31:0] res_key;
  logic        [31:0] res_value;

  logic [CNT_W-1:0]  parent;
  logic [CNT_W:0]    kid;
  logic              has_right;
  logic              right_less;
  pair_t             child;
  logic [CNT_W-1:0]  child_pos;

  // Tree navigation and key compares.
  assign parent     = pos >> 1;
  assign kid        = {pos, 1'b0};
  assign has_right  = kid < {1'b0, count};
  assign right_less = has_right && key_less(rd_b.key, rd_a.key);
  assign child      = right_less ? rd_b : rd_a;
  assign child_pos  = right_less ? CNT_W'(kid + 1'b1) : CNT_W'(kid);

  assign stat.full     = count >= CNT_W'(CAPACITY);
  assign stat.empty    = (count == '0);
  assign stat.last_one = (count == CNT_W'(1));
  assign stat.up_root  = (pos == CNT_W'(1));
  assign stat.up_go    = key_less(mov.key, rd_a.key);
  assign stat.dn_leaf  = kid > {1'b0, count};
  assign stat.dn_go    = key_less(child.key, mov.key);

  // Memory addresses and next register values for each command.
  always_comb begin
    rd_en      = 1'b0;
    ra_addr    = ADDR_W'(parent - 1'b1);
    rb_addr    = ADDR_W'(count - 1'b1);
    wr_en      = 1'b0;
    wr_addr    = ADDR_W'(pos - 1'b1);
    wr_data    = mov;
    count_next = count;
    pos_next   = pos;
    mov_next   = mov;
    case (cmd.op)
      OP_START: begin
        mov_next.key   = req.key;
        mov_next.value = req.value;
        if (req.mode == MODE_INSERT && !stat.full) begin
          count_next = count + 1'b1;
          pos_next   = count + 1'b1;
        end
      end
      OP_UP_PLACE: begin
        wr_en = 1'b1;
      end
      OP_UP_RD: begin
        rd_en = 1'b1;
      end
      OP_UP_STEP: begin
        // The parent moves down into the hole, or the new entry settles here.
        wr_en = 1'b1;
        if (stat.up_go) begin
          wr_data  = rd_a;
          pos_next = parent;
        end
      end
      OP_EX_RD: begin
        rd_en   = 1'b1;
        ra_addr = '0;
      end
      OP_EX_LOAD: begin
        mov_next   = rd_b;
        count_next = count - 1'b1;
        pos_next   = CNT_W'(1);
      end
      OP_DN_PLACE: begin
        wr_en = 1'b1;
      end
      OP_DN_RD: begin
        rd_en   = 1'b1;
        ra_addr = ADDR_W'(kid - 1'b1);
        rb_addr = ADDR_W'(kid);
      end
      OP_DN_STEP: begin
        // The smaller child moves up into the hole, or the last entry settles.
        wr_en = 1'b1;
        if (stat.dn_go) begin
          wr_data  = child;
          pos_next = child_pos;
        end
      end
      default: begin
      end
    endcase
  end

  // Heap memory with one write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a <= mem[ra_addr];
      rd_b <= mem[rb_addr];
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Working registers and the result of the current item.
  always_ff @(posedge clk) begin
    pos <= pos_next;
    mov <= mov_next;
    case (cmd.op)
      OP_START: begin
        res_key   <= '0;
        res_value <= '0;
        if (req.mode == MODE_INSERT) begin
          res_status <= stat.full ? STAT_FULL : STAT_DONE;
        end else begin
          res_status <= stat.empty ? STAT_EMPTY : STAT_DONE;
        end
      end
      OP_EX_LOAD: begin
        res_key   <= rd_a.key;
        res_value <= rd_a.value;
      end
      default: begin
      end
    endcase
    if (cmd.out_load) begin
      rsp.status    <= res_status;
      rsp.out_key   <= res_key;
      rsp.out_value <= res_value;
      rsp.count     <= COUNT_W'(count);
    end
  end

endmodule

`default_nettype wire

FILE: design/bmhq_ctrl.sv
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Sequencer for insert (sift up) and extract (sift down), plus the
// response valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  bmhq_pkg::mode_t req_mode,
  input  bmhq_pkg::stat_t stat,
  input  logic            rsp_stall,
  output logic            req_stall,
  output logic            rsp_valid,
  output bmhq_pkg::cmd_t  cmd
);
  import bmhq_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Response valid: set when a result loads, cleared when it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  assign req_stall = (state != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next   = state;
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.op = OP_START;
          if (req_mode == MODE_INSERT) begin
            state_next = stat.full ? S_FIN : S_UP_RD;
          end else begin
            state_next = stat.empty ? S_FIN : S_EX_RD;
          end
        end
      end
      S_UP_RD: begin
        if (stat.up_root) begin
          cmd.op     = OP_UP_PLACE;
          state_next = S_FIN;
        end else begin
          cmd.op     = OP_UP_RD;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd.op     = OP_UP_STEP;
        state_next = stat.up_go ? S_UP_RD : S_FIN;
      end
      S_EX_RD: begin
        cmd.op     = OP_EX_RD;
        state_next = S_EX_LOAD;
      end
      S_EX_LOAD: begin
        cmd.op     = OP_EX_LOAD;
        state_next = stat.last_one ? S_FIN : S_DN_RD;
      end
      S_DN_RD: begin
        if (stat.dn_leaf) begin
          cmd.op     = OP_DN_PLACE;
          state_next = S_FIN;
        end else begin
          cmd.op     = OP_DN_RD;
          state_next = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        cmd.op     = OP_DN_STEP;
        state_next = stat.dn_go ? S_DN_RD : S_FIN;
      end
      S_FIN: begin
        // Hand the result over once the output register is free.
        if (!rsp_valid || !rsp_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/binary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Min-heap priority queue of signed key / value pairs with insert and
// extract-minimum operations.
// ----------------------------------------------------------------------------
//   Channel  Dir  Handshake            Payload
//   req      in   req_valid/req_stall  mode, key, value
//   rsp      out  rsp_valid/rsp_stall  status, out_key, out_value, count
//
// After a request transfer, an insert alternates a parent read and a compare
// (S_UP_RD, S_UP_CMP) until its entry reaches the root or a compare stops it;
// an extract reads root and last entry and sifts down; then the result loads.
// Reset clears the count and the sequencer; the heap memory is not cleared.
// A stalled result holds in the output register; the next request is taken
// meanwhile and its result waits for that register to free up.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_min_heap_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  bmhq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output bmhq_pkg::rsp_t rsp
);
  import bmhq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bmhq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_mode  (req.mode),
    .stat      (stat),
    .rsp_stall (rsp_stall),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .cmd       (cmd)
  );

  bmhq_datapath u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule

`default_nettype wire

FILE: design/bmhq_checker.sv
// ----------------------------------------------------------------------------
// bmhq_checker
// Port-level checks of the min-heap queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_min_heap_queue_macros.svh"

module bmhq_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input bmhq_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input bmhq_pkg::rsp_t rsp
);
  import bmhq_pkg::*;

  // An extract from an empty heap leaves it empty and returns zeros.
  `BMHQ_ASSERT_IMPL(a_empty_result, clk, rst, rsp_valid && rsp.status == STAT_EMPTY, rsp.out_key == 0 && rsp.out_value == 0 && rsp.count == 0)

  // A refused insert only happens with the heap at capacity.
  `BMHQ_ASSERT_IMPL(a_full_count, clk, rst, rsp_valid && rsp.status == STAT_FULL, rsp.count == COUNT_W'(CAPACITY))

  // A request transfer makes the block busy in the following cycle.
  `BMHQ_ASSERT_NEXT(a_busy_after_req, clk, rst, req_valid && !req_stall, req_stall)

  // A stalled result stays valid and unchanged.
  `BMHQ_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

endmodule

bind binary_min_heap_queue bmhq_checker u_bmhq_checker (.*);

`default_nettype wire

FILE: sim/heap_queue_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Heap queue monitor
// Watches both channels of the min-heap queue, keeps its own copy of the heap
// to work out each result, and compares every result transfer against the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------

module heap_queue_monitor (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  bmhq_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  bmhq_pkg::rsp_t rsp,
  output int             errors,
  output int             pending
);
  import bmhq_pkg::*;

  // Shadow heap, one-based like the block's heap positions.
  pair_t       heap_mem [1:CAPACITY];
  int unsigned held = 0;
  int          mismatches = 0;

  // Predicted results in request order.
  rsp_t        awaited_results [$];

  function automatic void swap_entries(int unsigned a, int unsigned b);
    pair_t t;
    t           = heap_mem[a];
    heap_mem[a] = heap_mem[b];
    heap_mem[b] = t;
  endfunction

  // Applies one request to the shadow heap and returns the result it causes.
  function automatic rsp_t heap_apply(req_t r);
    rsp_t        res;
    int unsigned pos;
    int unsigned up;
    int unsigned kid;
    bit          walking;
    res        = '0;
    res.status = STAT_DONE;
    if (r.mode == MODE_INSERT) begin
      if (held >= CAPACITY) begin
        res.status = STAT_FULL;
      end else begin
        // Append, then sift up while the parent key is strictly greater.
        held++;
        heap_mem[held].key   = r.key;
        heap_mem[held].value = r.value;
        pos     = held;
        walking = 1'b1;
        while (walking && pos > 1) begin
          up = pos / 2;
          if ($signed(heap_mem[pos].key) < $signed(heap_mem[up].key)) begin
            swap_entries(pos, up);
            pos = up;
          end else begin
            walking = 1'b0;
          end
        end
      end
    end else if (held == 0) begin
      res.status = STAT_EMPTY;
    end else begin
      // Take the root, move the last entry up and sift it down. The right
      // child wins only on a strictly smaller key.
      res.out_key   = heap_mem[1].key;
      res.out_value = heap_mem[1].value;
      heap_mem[1]   = heap_mem[held];
      held--;
      pos     = 1;
      walking = 1'b1;
      while (walking && 2 * pos <= held) begin
        kid = 2 * pos;
        if (kid + 1 <= held &&
            $signed(heap_mem[kid + 1].key) < $signed(heap_mem[kid].key)) begin
          kid++;
        end
        if ($signed(heap_mem[kid].key) < $signed(heap_mem[pos].key)) begin
          swap_entries(kid, pos);
          pos = kid;
        end else begin
          walking = 1'b0;
        end
      end
    end
    res.count = COUNT_W'(held);
    return res;
  endfunction

  // Results are checked before the request of the same edge is predicted,
  // since a result can never belong to a request taken at that same edge.
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      held = 0;
      awaited_results.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result transfer: status %0d key %0d value %0h count %0d",
                 rsp.status, rsp.out_key, rsp.out_value, rsp.count);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
            mismatches++;
          end
          if (rsp.out_key !== want.out_key) begin
            $error("out_key: expected %0d, actual %0d", want.out_key, rsp.out_key);
            mismatches++;
          end
          if (rsp.out_value !== want.out_value) begin
            $error("out_value: expected %0h, actual %0h", want.out_value, rsp.out_value);
            mismatches++;
          end
          if (rsp.count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, rsp.count);
            mismatches++;
          end
        end
      end
      if (req_valid && !req_stall) begin
        awaited_results.push_back(heap_apply(req));
      end
    end
    pending <= awaited_results.size();
    errors  <= mismatches;
  end

endmodule

FILE: sim/binary_min_heap_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Min-heap queue testbench
// Drives insert and extract requests in random bursts against a receiver that
// stalls on its own pattern, covers empty extracts, signed key extremes and
// ties, and leaves all checking to the heap queue monitor.
// ----------------------------------------------------------------------------

module binary_min_heap_queue_tb;
  import bmhq_pkg::*;

  localparam int LIMIT = 600_000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;
  int   errors;
  int   pending;

  // Sender bookkeeping: expected occupancy and what the run has reached.
  int unsigned burst_left = 0;
  int unsigned occupancy = 0;
  int unsigned peak = 0;
  int unsigned n_items = 0;
  int unsigned n_empty_tries = 0;
  int unsigned n_full_tries = 0;

  binary_min_heap_queue dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  heap_queue_monitor u_monitor (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic req_t make_req(mode_t m, logic [31:0] k, logic [31:0] v);
    req_t r;
    r.mode  = m;
    r.key   = k;
    r.value = v;
    return r;
  endfunction

  // Keys: full range, a narrow band full of ties, zero, minus one, and values
  // at or near the signed extremes.
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 5))
      0, 1: return $urandom();
      2: return 32'($urandom_range(0, 15)) - 32'd8;
      3: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      4: return 32'h8000_0000 + 32'($urandom_range(0, 3));
      default: return 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
    endcase
  endfunction

  // Offers one request and returns at the edge of its transfer. A new burst
  // may open with a gap; within a burst valid stays high.
  task automatic offer(input req_t item);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    if (item.mode == MODE_INSERT) begin
      if (occupancy == CAPACITY) n_full_tries++;
      else occupancy++;
    end else if (occupancy == 0) begin
      n_empty_tries++;
    end else begin
      occupancy--;
    end
    if (occupancy > peak) peak = occupancy;
    n_items++;
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  // Receiver: changing stall styles, with two long hold-offs that back the
  // block up into its request channel.
  initial begin
    int unsigned cyc;
    int unsigned run_left;
    int unsigned style;
    cyc       = 0;
    run_left  = 0;
    style     = 0;
    rsp_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      cyc++;
      if ((cyc >= 3000 && cyc < 3500) || (cyc >= 40000 && cyc < 40800)) begin
        rsp_stall <= 1'b1;
      end else begin
        if (run_left == 0) begin
          style    = $urandom_range(0, 3);
          run_left = $urandom_range(16, 256);
        end
        run_left--;
        case (style)
          0: rsp_stall <= 1'b0;
          1: rsp_stall <= 1'($urandom_range(0, 1));
          2: rsp_stall <= ($urandom_range(0, 3) != 0);
          default: rsp_stall <= cyc[3];
        endcase
      end
    end
  end

  // Watchdog on total run length.
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped at the cycle limit of %0d.", LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    int unsigned ins_pct;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Extracts from an empty heap, the signed key extremes, ties, then a full
    // drain and one more empty extract.
    offer(make_req(MODE_EXTRACT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    offer(make_req(MODE_EXTRACT, 32'h0000_0000, 32'h0000_0000));
    offer(make_req(MODE_INSERT, 32'h7FFF_FFFF, 32'h0000_0000));
    offer(make_req(MODE_INSERT, 32'h8000_0000, 32'hFFFF_FFFF));
    offer(make_req(MODE_INSERT, 32'h0000_0000, 32'hA5A5_A5A5));
    offer(make_req(MODE_INSERT, 32'hFFFF_FFFF, 32'h5A5A_5A5A));
    offer(make_req(MODE_INSERT, 32'h0000_0001, 32'h0000_0001));
    offer(make_req(MODE_INSERT, 32'h0000_0000, 32'h0000_0002));
    offer(make_req(MODE_INSERT, 32'h0000_0000, 32'h0000_0003));
    offer(make_req(MODE_INSERT, 32'hFFFF_FFFF, 32'h0000_0004));
    offer(make_req(MODE_INSERT, 32'h8000_0000, 32'h0000_0005));
    repeat (10) offer(make_req(MODE_EXTRACT, $urandom(), $urandom()));

    // Random mix in segments that let the heap grow, hover and shrink.
    repeat (11) begin
      case ($urandom_range(0, 2))
        0: ins_pct = 25;
        1: ins_pct = 55;
        default: ins_pct = 80;
      endcase
      repeat (50) begin
        offer(make_req(($urandom_range(1, 100) <= ins_pct) ? MODE_INSERT : MODE_EXTRACT,
                       pick_key(), $urandom()));
      end
    end

    // A closing run of extracts that drains much or all of what is left.
    repeat (29) offer(make_req(MODE_EXTRACT, $urandom(), $urandom()));
    req_valid <= 1'b0;

    // Wait for every predicted result, then a little longer for strays.
    do @(posedge clk); while (pending != 0);
    repeat (60) @(posedge clk);

    $display("Sent %0d requests: %0d extracts on an empty heap, %0d inserts on a full one.",
             n_items, n_empty_tries, n_full_tries);
    $display("Heap occupancy peaked at %0d of %0d entries.", peak, CAPACITY);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/bmhq_pkg.sv
design/bmhq_datapath.sv
design/bmhq_ctrl.sv
design/binary_min_heap_queue.sv
design/bmhq_checker.sv
sim/heap_queue_monitor.sv
sim/binary_min_heap_queue_tb.sv
